[rtl/core/bilinear_texture_sampler_assert.svh]
// Assertion macros shared by the sampler RTL.
// BTS_ASSERT_NOW: antecedent and consequent in the same cycle.
// BTS_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear sampler check failed");
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear sampler check failed");
`else
`define BTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/bts_pkg.sv]
package bts_pkg;

    // Item field widths
    localparam int COORD_W   = 24;
    localparam int EXT_W     = 32;
    localparam int INDEX_W   = 8;
    localparam int TEXEL_W   = 32;
    localparam int S_TDATA_W = 96;
    localparam int SIZE_W    = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd8;

    // Register indexes (paddr[2])
    localparam logic REG_WIDTH_LOG2  = 1'b0;
    localparam logic REG_HEIGHT_LOG2 = 1'b1;

    // Item kinds
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] width_log2;
        logic [SIZE_W-1:0] height_log2;
    } t_cfg;

    // Select one bank's read data; sel = {row parity, column parity}
    function automatic logic [TEXEL_W-1:0] pick_texel(
        input logic [1:0]         sel,
        input logic [TEXEL_W-1:0] d0,
        input logic [TEXEL_W-1:0] d1,
        input logic [TEXEL_W-1:0] d2,
        input logic [TEXEL_W-1:0] d3
    );
        logic [TEXEL_W-1:0] res;
        case (sel)
            2'd0:    res = d0;
            2'd1:    res = d1;
            2'd2:    res = d2;
            2'd3:    res = d3;
            default: res = d0;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/bts_ram.sv]
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bts_lerp.sv]
module bts_lerp
    import bts_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic [TEXEL_W-1:0]   i_a,
    input  logic [TEXEL_W-1:0]   i_b,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic [TEXEL_W-1:0]   o_c
);
    localparam int          PW  = 9 + FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [FRAC_BITS:0] w_wa;
    logic [FRAC_BITS:0] w_wb;

    assign w_wb = {1'b0, i_t};
    assign w_wa = ONE - w_wb;

    // Per channel: (a*(ONE-t) + b*t) >> FRAC_BITS, truncated to 8 bits
    always_comb begin
        logic [PW-1:0] sum;
        o_c = '0;
        for (int ch = 0; ch < 4; ch++) begin
            sum = PW'(i_a[8*ch +: 8]) * PW'(w_wa) + PW'(i_b[8*ch +: 8]) * PW'(w_wb);
            o_c[8*ch +: 8] = sum[FRAC_BITS +: 8];
        end
    end

endmodule

[rtl/core/bts_cfg.sv]
module bts_cfg
    import bts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);
    t_cfg r_cfg;
    logic w_wr;
    logic w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    // Register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_log2  <= SIZE_LOG2_RESET;
            r_cfg.height_log2 <= SIZE_LOG2_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_WIDTH_LOG2:  r_cfg.width_log2  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT_LOG2: r_cfg.height_log2 <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_WIDTH_LOG2:  prdata = CFG_DATA_W'(r_cfg.width_log2);
            REG_HEIGHT_LOG2: prdata = CFG_DATA_W'(r_cfg.height_log2);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/bilinear_texture_sampler.sv]
// Channel      Dir  Handshake             Payload
// s (items)    in   i_s_tvalid/o_s_tready tdata 96b, tuser = func
// m (results)  out  o_m_tvalid/i_m_tready tdata = color
// apb (config) in   psel/penable/pwrite   paddr 3b, 32b data, pready tied high
//
// One item per cycle unless a stalled result fills all stages. A sample item raises
// o_m_tvalid after bank read, horizontal blend, vertical blend into output register.
// A write item stores its texel at the accepting edge and yields no result.
// The texture sits in four RAM banks split by column and row parity, so the four
// neighbors of a sample come out of one read of the banks.
// Reset is synchronous; it clears the stage valids and sets both size registers
// to 8. Texture memory is not cleared. Each stage takes a new item when it is
// empty or its contents move on, so a stalled result lets items enter until
// all three stages hold samples.
module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = 8,
    parameter int FRAC_BITS     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: coord_x[23:0], coord_y[47:24], texel_col[55:48], texel_row[63:56],
    //        texel_value[95:64]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: func
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: color[31:0]
    output logic [TEXEL_W-1:0]    o_m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int M          = MAX_SIZE_LOG2;
    localparam int BANK_AW    = (2*M - 2 > 0) ? 2*M - 2 : 1;
    localparam int BANK_DEPTH = 1 << (2*M - 2);

    t_cfg w_cfg;

    // Input unpack
    logic                 w_func;
    logic [COORD_W-1:0]   w_x, w_y;
    logic [EXT_W-1:0]     w_xs, w_ys;
    logic [INDEX_W-1:0]   w_col_in, w_row_in;
    logic [TEXEL_W-1:0]   w_value;
    logic [M-1:0]         w_wcol, w_wrow;
    logic [FRAC_BITS-1:0] w_tx, w_ty;
    logic [M-1:0]         w_ix, w_iy;
    logic [M-1:0]         w_c0, w_c1, w_r0, w_r1;
    logic [SIZE_W-1:0]    w_wlg, w_hlg;
    logic [M-1:0]         w_wmask, w_hmask;

    // Handshake and stage control
    logic w_acc, w_rd, w_adv1, w_adv2, w_adv3;
    logic r_v1, r_v2, r_v3;

    // Bank ports
    logic [BANK_AW-1:0] w_addr  [4];
    logic               w_we    [4];
    logic [TEXEL_W-1:0] w_rdata [4];

    // Stage 1 (bank read) side info
    logic                 r_pc0, r_pc1, r_pr0, r_pr1;
    logic [FRAC_BITS-1:0] r_tx1, r_ty1;
    logic [TEXEL_W-1:0]   w_c00, w_c10, w_c01, w_c11;
    logic [TEXEL_W-1:0]   n_top, n_bot;

    // Stage 2 (horizontal blends)
    logic [TEXEL_W-1:0]   r_top, r_bot;
    logic [FRAC_BITS-1:0] r_ty2;
    logic [TEXEL_W-1:0]   n_color;

    // Stage 3 (output register)
    logic [TEXEL_W-1:0]   r_color;

    bts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_func   = i_s_tuser;
    assign w_x      = i_s_tdata[23:0];
    assign w_y      = i_s_tdata[47:24];
    assign w_col_in = i_s_tdata[55:48];
    assign w_row_in = i_s_tdata[63:56];
    assign w_value  = i_s_tdata[95:64];
    assign w_wcol   = M'(w_col_in);
    assign w_wrow   = M'(w_row_in);

    // Floor and fraction in two's complement
    assign w_xs = {{(EXT_W-COORD_W){w_x[COORD_W-1]}}, w_x};
    assign w_ys = {{(EXT_W-COORD_W){w_y[COORD_W-1]}}, w_y};
    assign w_tx = w_xs[FRAC_BITS-1:0];
    assign w_ty = w_ys[FRAC_BITS-1:0];
    assign w_ix = w_xs[FRAC_BITS +: M];
    assign w_iy = w_ys[FRAC_BITS +: M];

    // Repeat-wrap masks, size saturated to MAX_SIZE_LOG2 where it is used
    assign w_wlg = (32'(w_cfg.width_log2) > M) ? SIZE_W'(M) : w_cfg.width_log2;
    assign w_hlg = (32'(w_cfg.height_log2) > M) ? SIZE_W'(M) : w_cfg.height_log2;
    assign w_wmask = M'(((M+1)'(1) << w_wlg) - (M+1)'(1));
    assign w_hmask = M'(((M+1)'(1) << w_hlg) - (M+1)'(1));

    assign w_c0 = w_ix & w_wmask;
    assign w_c1 = (w_ix + M'(1)) & w_wmask;
    assign w_r0 = w_iy & w_hmask;
    assign w_r1 = (w_iy + M'(1)) & w_hmask;

    // Stage advance: a stage moves when empty or when its contents move on
    assign w_adv3     = !r_v3 || i_m_tready;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_s_tready = w_adv1;
    assign w_acc      = i_s_tvalid && w_adv1;
    assign w_rd       = w_acc && (w_func == FUNC_SAMPLE);

    // Four parity banks; bank b holds column parity b%2 and row parity b/2.
    // Items are taken in order, so a write always lands before a later read.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);

        logic [M-1:0]   col, row, col_h, row_h;
        logic [2*M-1:0] lin;

        always_comb begin
            if (w_func == FUNC_WRITE) begin
                col = w_wcol;
                row = w_wrow;
            end else begin
                col = (w_c0[0] == PX) ? w_c0 : w_c1;
                row = (w_r0[0] == PY) ? w_r0 : w_r1;
            end
            col_h = col >> 1;
            row_h = row >> 1;
            lin   = ({{M{1'b0}}, row_h} << (M - 1)) | {{M{1'b0}}, col_h};
        end

        assign w_addr[b] = BANK_AW'(lin);
        assign w_we[b]   = w_acc && (w_func == FUNC_WRITE)
                           && (w_wcol[0] == PX) && (w_wrow[0] == PY);

        bts_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_addr[b]),
            .i_wdata (w_value),
            .i_re    (w_rd),
            .i_raddr (w_addr[b]),
            .o_rdata (w_rdata[b])
        );
    end

    // Route bank data back to the four neighbors
    assign w_c00 = pick_texel({r_pr0, r_pc0}, w_rdata[0], w_rdata[1], w_rdata[2], w_rdata[3]);
    assign w_c10 = pick_texel({r_pr0, r_pc1}, w_rdata[0], w_rdata[1], w_rdata[2], w_rdata[3]);
    assign w_c01 = pick_texel({r_pr1, r_pc0}, w_rdata[0], w_rdata[1], w_rdata[2], w_rdata[3]);
    assign w_c11 = pick_texel({r_pr1, r_pc1}, w_rdata[0], w_rdata[1], w_rdata[2], w_rdata[3]);

    bts_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_top (
        .i_a (w_c00),
        .i_b (w_c10),
        .i_t (r_tx1),
        .o_c (n_top)
    );

    bts_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_bot (
        .i_a (w_c01),
        .i_b (w_c11),
        .i_t (r_tx1),
        .o_c (n_bot)
    );

    bts_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_vert (
        .i_a (r_top),
        .i_b (r_bot),
        .i_t (r_ty2),
        .o_c (n_color)
    );

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_rd;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_pc0 <= w_c0[0];
            r_pc1 <= w_c1[0];
            r_pr0 <= w_r0[0];
            r_pr1 <= w_r1[0];
            r_tx1 <= w_tx;
            r_ty1 <= w_ty;
        end
        if (w_adv2) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_ty2 <= r_ty1;
        end
        if (w_adv3) begin
            r_color <= n_color;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_color;

`include "bilinear_texture_sampler_assert.svh"

    // Neighbor columns share a parity only when the texture is one texel wide
    `BTS_ASSERT_NOW(a_col_parity, i_clk, i_rst_n, r_v1 && (r_pc0 == r_pc1), !r_pc0)
    // Same for rows
    `BTS_ASSERT_NOW(a_row_parity, i_clk, i_rst_n, r_v1 && (r_pr0 == r_pr1), !r_pr0)
    // A held read stage keeps its bank data (banks 0 and 3 checked)
    `BTS_ASSERT_NEXT(a_rd_hold, i_clk, i_rst_n, r_v1 && !w_adv2, $stable(w_rdata[0]) && $stable(w_rdata[3]))
    // A result only appears after the blend stage held an item
    `BTS_ASSERT_NOW(a_out_src, i_clk, i_rst_n, $rose(r_v3), $past(r_v2))

endmodule
